@@ rtl/sctp_data_receive_reorder_macros.svh @@
// assertion macros for the sctp data receive reorder block
// used by the checker module only
`ifndef SCTP_DATA_RECEIVE_REORDER_MACROS_SVH
`define SCTP_DATA_RECEIVE_REORDER_MACROS_SVH
`define SDR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/sdr_pkg.sv @@
// types and constants for the sctp data receive reorder block
// no dependencies
package sdr_pkg;
  localparam int unsigned HdrBytes = 4 + 12;
  localparam logic [15:0] SsnHalf = 16'h8000;
  localparam logic [1:0] RegPeerTsn = 2'd0;
  localparam logic [1:0] RegAckOn = 2'd1;
  localparam logic [1:0] RegMaxPay = 2'd2;
  localparam logic RkDeliver = 1'b0;
  localparam logic RkSack = 1'b1;

  typedef struct packed {
    logic [31:0] chunk_tsn;
    logic [15:0] stream_number;
    logic [15:0] stream_seq;
    logic [31:0] protocol_id;
    logic        unordered_flag;
    logic [15:0] chunk_length;
    logic [15:0] bytes_available;
    logic [15:0] payload_handle;
  } sdr_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] out_stream;
    logic [31:0] out_protocol_id;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [31:0] cumulative_ack;
    logic        last_result;
  } sdr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_ORDER, ST_SCAN, ST_SACK
  } sdr_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic advance_ack;
    logic bump_exp;
    logic park;
    logic scan_clr;
    logic scan_step;
    logic take_hit;
    logic emit_cur;
    logic emit_pend;
    logic emit_sack;
    logic emit_last;
  } sdr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic dup;
    logic unordered;
    logic in_order;
    logic future;
    logic scan_done;
    logic hit;
    logic out_busy;
  } sdr_stat_t;
endpackage

@@ rtl/sctp_data_receive_reorder.sv @@
// SCTP DATA chunk receive path with per-stream ordering. An accepted chunk
// is loaded, then checked: a bad chunk is dropped, a duplicate gets only a
// SACK when tracking is on, and any other chunk is delivered if unordered, or
// parked or dropped as old, followed by its SACK when tracking is on. An
// in-order delivery adds a walk over the pending table, and each parked entry
// drained adds another walk, since every pass restarts at the first entry.
// Results leave through one output register; downstream stall holds the sequencer.
// Depends on sdr_pkg, sdr_ctrl and sdr_datapath.
module sctp_data_receive_reorder import sdr_pkg::*; #(
  parameter int STREAM_COUNT = 16,
  parameter int REORDER_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sdr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output sdr_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  sdr_cmd_t cmd;
  sdr_stat_t st;
  logic ack_on, cfg_we;
  logic [31:0] rd_peer;
  logic [15:0] rd_max;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00)
                  && (paddr[3:2] != 2'd3);

  always_comb begin
    unique case (paddr[3:2])
      RegPeerTsn: prdata = rd_peer;
      RegAckOn: prdata = {31'd0, ack_on};
      RegMaxPay: prdata = {16'd0, rd_max};
      default: prdata = '0;
    endcase
  end

  sdr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .ack_on(ack_on),
    .st(st), .in_stall(in_stall), .cmd(cmd)
  );

  sdr_datapath #(.STREAM_COUNT(STREAM_COUNT), .REORDER_DEPTH(REORDER_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_idx(paddr[3:2]), .cfg_data(pwdata), .out_stall(out_stall), .st(st),
    .ack_on(ack_on), .rd_peer(rd_peer), .rd_max(rd_max), .out_valid(out_valid),
    .out_item(out_data)
  );
endmodule

@@ rtl/sdr_ctrl.sv @@
// control state machine for the sctp data receive reorder block
// depends on sdr_pkg
module sdr_ctrl import sdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      ack_on,
  input  sdr_stat_t st,
  output logic      in_stall,
  output sdr_cmd_t  cmd
);
  sdr_state_t state, state_next;
  logic from_table, from_table_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      from_table <= 1'b0;
    end else begin
      state <= state_next;
      from_table <= from_table_next;
    end
  end

  always_comb begin
    state_next = state;
    from_table_next = from_table;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.bad) state_next = ST_IDLE;
        else if (ack_on && st.dup) state_next = ST_SACK;
        else begin
          cmd.advance_ack = ack_on;
          state_next = ST_ORDER;
        end
      end
      ST_ORDER: begin
        if (!st.out_busy) begin
          if (st.unordered) begin
            cmd.emit_cur = 1'b1;
            cmd.emit_last = !ack_on;
            state_next = ack_on ? ST_SACK : ST_IDLE;
          end else if (st.in_order) begin
            // delivery is held until the scan tells whether more follow
            cmd.bump_exp = 1'b1;
            cmd.scan_clr = 1'b1;
            from_table_next = 1'b0;
            state_next = ST_SCAN;
          end else begin
            cmd.park = st.future;
            state_next = ack_on ? ST_SACK : ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (st.hit) begin
          if (!st.out_busy) begin
            cmd.emit_cur = !from_table;
            cmd.emit_pend = from_table;
            cmd.take_hit = 1'b1;
            cmd.bump_exp = 1'b1;
            cmd.scan_clr = 1'b1;
            from_table_next = 1'b1;
          end
        end else if (st.scan_done) begin
          if (!st.out_busy) begin
            cmd.emit_cur = !from_table;
            cmd.emit_pend = from_table;
            cmd.emit_last = !ack_on;
            state_next = ack_on ? ST_SACK : ST_IDLE;
          end
        end else cmd.scan_step = 1'b1;
      end
      ST_SACK: begin
        if (!st.out_busy) begin
          cmd.emit_sack = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ rtl/sdr_datapath.sv @@
// registers, stream table, pending table and output stage
// depends on sdr_pkg
module sdr_datapath import sdr_pkg::*; #(
  parameter int STREAM_COUNT = 16,
  parameter int REORDER_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  sdr_in_t     in_item,
  input  sdr_cmd_t    cmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        out_stall,
  output sdr_stat_t   st,
  output logic        ack_on,
  output logic [31:0] rd_peer,
  output logic [15:0] rd_max,
  output logic        out_valid,
  output sdr_out_t    out_item
);
  localparam int SW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int PW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;

  logic [31:0] init_tsn, cum_ack;
  logic [15:0] max_pay;
  sdr_in_t     cur;
  logic [15:0] plen;
  logic [15:0] exp_seq [STREAM_COUNT];
  logic [REORDER_DEPTH-1:0] pvalid;
  logic [SW-1:0] p_stream [REORDER_DEPTH];
  logic [15:0] p_seq [REORDER_DEPTH];
  logic [31:0] p_proto [REORDER_DEPTH];
  logic [15:0] p_handle [REORDER_DEPTH];
  logic [15:0] p_len [REORDER_DEPTH];
  logic [PW-1:0] scan_idx, free_idx, hit_idx;
  logic free_found;
  logic [SW-1:0] sid;
  logic [15:0] cur_exp;
  logic [31:0] tsn_diff;
  logic [15:0] ssn_diff;
  logic hit_now;
  logic emit_any;
  sdr_out_t out_build;

  assign sid = cur.stream_number[SW-1:0];
  assign cur_exp = exp_seq[sid];
  assign tsn_diff = cur.chunk_tsn - cum_ack;
  assign ssn_diff = cur.stream_seq - cur_exp;
  assign plen = cur.chunk_length - 16'(HdrBytes);
  assign hit_now = pvalid[scan_idx] && (p_stream[scan_idx] == sid)
                   && (p_seq[scan_idx] == cur_exp);
  assign emit_any = cmd.emit_cur || cmd.emit_pend || cmd.emit_sack;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = REORDER_DEPTH - 1; i >= 0; i--) begin
      if (!pvalid[i]) begin
        free_found = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  always_comb begin
    st = '0;
    st.bad = (cur.bytes_available < 16'(HdrBytes)) || (cur.chunk_length < 16'(HdrBytes))
             || (cur.chunk_length > cur.bytes_available)
             || (32'(cur.stream_number) >= 32'(STREAM_COUNT)) || (plen > max_pay);
    st.dup = (tsn_diff == 32'd0) || tsn_diff[31];
    st.unordered = cur.unordered_flag;
    st.in_order = cur.stream_seq == cur_exp;
    st.future = (ssn_diff < SsnHalf) && free_found;
    st.scan_done = 32'(scan_idx) == 32'(REORDER_DEPTH - 1);
    st.hit = hit_now;
    st.out_busy = out_valid && out_stall;
  end

  always_comb begin
    out_build = '0;
    if (cmd.emit_pend) begin
      out_build.result_kind = RkDeliver;
      out_build.out_stream = 16'(p_stream[hit_idx]);
      out_build.out_protocol_id = p_proto[hit_idx];
      out_build.out_handle = p_handle[hit_idx];
      out_build.out_length = p_len[hit_idx];
    end else if (cmd.emit_sack) begin
      out_build.result_kind = RkSack;
      out_build.cumulative_ack = cum_ack;
    end else begin
      out_build.result_kind = RkDeliver;
      out_build.out_stream = cur.stream_number;
      out_build.out_protocol_id = cur.protocol_id;
      out_build.out_handle = cur.payload_handle;
      out_build.out_length = plen;
    end
    out_build.last_result = cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_tsn <= '0;
      cum_ack <= '1;
      ack_on <= 1'b0;
      max_pay <= 16'd1200;
      pvalid <= '0;
      scan_idx <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STREAM_COUNT; i++) exp_seq[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          RegPeerTsn: begin
            init_tsn <= cfg_data;
            cum_ack <= cfg_data - 32'd1;
          end
          RegAckOn: ack_on <= cfg_data[0];
          RegMaxPay: max_pay <= cfg_data[15:0];
          default: ;
        endcase
      end else if (cmd.advance_ack && tsn_diff == 32'd1) cum_ack <= cur.chunk_tsn;
      if (cmd.bump_exp) exp_seq[sid] <= cur_exp + 16'd1;
      if (cmd.park) pvalid[free_idx] <= 1'b1;
      else if (cmd.take_hit) pvalid[scan_idx] <= 1'b0;
      if (cmd.scan_clr) scan_idx <= '0;
      else if (cmd.scan_step) scan_idx <= scan_idx + PW'(1);
      if (emit_any) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_item;
    if (cmd.take_hit) hit_idx <= scan_idx;
    if (cmd.park) begin
      p_stream[free_idx] <= sid;
      p_seq[free_idx] <= cur.stream_seq;
      p_proto[free_idx] <= cur.protocol_id;
      p_handle[free_idx] <= cur.payload_handle;
      p_len[free_idx] <= plen;
    end
    if (emit_any) out_item <= out_build;
  end

  assign rd_peer = init_tsn;
  assign rd_max = max_pay;
endmodule

@@ rtl/sdr_checker.sv @@
// port-level checks for the sctp data receive reorder block
// depends on sdr_pkg and the macro header
`include "sctp_data_receive_reorder_macros.svh"
module sdr_checker import sdr_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sdr_out_t out_data
);
  `SDR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `SDR_ASSERT_IMPL(a_sack_clean, clk, rst, out_valid && out_data.result_kind == RkSack, out_data.last_result && out_data.out_handle == 16'd0)
  `SDR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind sctp_data_receive_reorder sdr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ verif/tb_sctp_data_receive_reorder.sv @@
// testbench for the sctp data receive reorder block: drives chunk headers and
// register writes, predicts deliveries and sacks, and checks every result
// depends on sdr_pkg and the sctp_data_receive_reorder rtl
module tb_sctp_data_receive_reorder;
  import sdr_pkg::*;

  localparam int NStreams = 16;
  localparam int NSlots = 8;

  typedef logic bool_t;

  class reorder_scoreboard;
    logic [31:0] tsn_base;
    logic        ack_on;
    logic [15:0] max_pay;
    logic [31:0] cum_ack;
    logic [15:0] exp_ssn [NStreams];
    logic        slot_used [NSlots];
    logic [15:0] slot_stream [NSlots];
    logic [15:0] slot_ssn [NSlots];
    logic [31:0] slot_ppid [NSlots];
    logic [15:0] slot_handle [NSlots];
    logic [15:0] slot_len [NSlots];
    sdr_out_t    pending_results [$];
    int          mismatches;

    function void clear();
      tsn_base = '0;
      ack_on = 1'b0;
      max_pay = 16'd1200;
      cum_ack = 32'hffff_ffff;
      for (int i = 0; i < NStreams; i++) exp_ssn[i] = '0;
      for (int i = 0; i < NSlots; i++) slot_used[i] = 1'b0;
      pending_results.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == RegPeerTsn) begin
        tsn_base = val;
        cum_ack = val - 32'd1;
      end else if (idx == RegAckOn) begin
        ack_on = val[0];
      end else if (idx == RegMaxPay) begin
        max_pay = val[15:0];
      end
    endfunction

    function void add_deliver(logic [15:0] sid, logic [31:0] ppid, logic [15:0] h,
                              logic [15:0] len, ref sdr_out_t rs [$]);
      sdr_out_t r;
      r = '0;
      r.result_kind = RkDeliver;
      r.out_stream = sid;
      r.out_protocol_id = ppid;
      r.out_handle = h;
      r.out_length = len;
      rs.push_back(r);
    endfunction

    function void note_chunk(sdr_in_t c);
      sdr_out_t rs [$];
      sdr_out_t r;
      logic [15:0] plen;
      logic [31:0] diff;
      logic [15:0] sid;
      logic [15:0] dssn;
      bool_t found;
      if (c.bytes_available < HdrBytes) return;
      if (c.chunk_length < HdrBytes || c.chunk_length > c.bytes_available) return;
      plen = c.chunk_length - 16'(HdrBytes);
      if (c.stream_number >= NStreams) return;
      if (plen > max_pay) return;
      sid = c.stream_number;
      if (ack_on) begin
        diff = c.chunk_tsn - cum_ack;
        if (diff == 32'd1) cum_ack = c.chunk_tsn;
        else if (diff == 0 || diff[31]) begin
          r = '0;
          r.result_kind = RkSack;
          r.cumulative_ack = cum_ack;
          r.last_result = 1'b1;
          pending_results.push_back(r);
          return;
        end
      end
      if (c.unordered_flag) begin
        add_deliver(sid, c.protocol_id, c.payload_handle, plen, rs);
      end else if (c.stream_seq == exp_ssn[sid[3:0]]) begin
        add_deliver(sid, c.protocol_id, c.payload_handle, plen, rs);
        exp_ssn[sid[3:0]]++;
        found = 1'b1;
        while (found) begin
          found = 1'b0;
          for (int i = 0; i < NSlots; i++) begin
            if (!found && slot_used[i] && slot_stream[i] == sid &&
                slot_ssn[i] == exp_ssn[sid[3:0]]) begin
              add_deliver(sid, slot_ppid[i], slot_handle[i], slot_len[i], rs);
              exp_ssn[sid[3:0]]++;
              slot_used[i] = 1'b0;
              found = 1'b1;
            end
          end
        end
      end else begin
        dssn = c.stream_seq - exp_ssn[sid[3:0]];
        if (dssn < SsnHalf) begin
          found = 1'b0;
          for (int i = 0; i < NSlots; i++) begin
            if (!found && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_stream[i] = sid;
              slot_ssn[i] = c.stream_seq;
              slot_ppid[i] = c.protocol_id;
              slot_handle[i] = c.payload_handle;
              slot_len[i] = plen;
              found = 1'b1;
            end
          end
        end
      end
      if (ack_on) begin
        r = '0;
        r.result_kind = RkSack;
        r.cumulative_ack = cum_ack;
        rs.push_back(r);
      end
      if (rs.size() > 0) rs[rs.size() - 1].last_result = 1'b1;
      foreach (rs[i]) pending_results.push_back(rs[i]);
    endfunction

    function void check_result(sdr_out_t got);
      sdr_out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  sdr_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  sdr_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  reorder_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  logic [15:0] next_tx_ssn [NStreams];
  logic [31:0] next_tx_tsn;

  sctp_data_receive_reorder u_top (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_chunk(sdr_in_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    sb.note_chunk(c);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic sdr_in_t make_chunk(logic [31:0] tsn, logic [15:0] sid,
                                         logic [15:0] ssn, logic uo, logic [15:0] plen);
    sdr_in_t c;
    c.chunk_tsn = tsn;
    c.stream_number = sid;
    c.stream_seq = ssn;
    c.protocol_id = $urandom;
    c.unordered_flag = uo;
    c.chunk_length = plen + 16'(HdrBytes);
    c.bytes_available = c.chunk_length + 16'($urandom_range(3));
    c.payload_handle = 16'($urandom);
    return c;
  endfunction

  task automatic random_phase(int n);
    sdr_in_t c;
    logic [3:0] sid;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      sid = 4'($urandom_range(NStreams - 1));
      if (k < 75) begin
        // mostly well formed, small ssn jumps to exercise parking
        c = make_chunk(next_tx_tsn, 16'(sid), next_tx_ssn[sid] + 16'($urandom_range(3)),
                       ($urandom_range(9) == 0), 16'($urandom_range(300)));
        if ($urandom_range(9) != 0) next_tx_tsn++;
        if ($urandom_range(2) == 0) c.chunk_tsn = c.chunk_tsn - 32'($urandom_range(3));
        if (c.stream_seq == next_tx_ssn[sid]) next_tx_ssn[sid]++;
        else if ($urandom_range(3) == 0) next_tx_ssn[sid] = c.stream_seq + 16'd1;
      end else begin
        c.chunk_tsn = $urandom;
        c.stream_number = 16'($urandom);
        c.stream_seq = 16'($urandom);
        c.protocol_id = $urandom;
        c.unordered_flag = 1'($urandom);
        c.chunk_length = 16'($urandom);
        c.bytes_available = 16'($urandom);
        c.payload_handle = 16'($urandom);
        if (k < 90) begin
          c.stream_number[15:4] = '0;
          c.chunk_length = 16'(HdrBytes) + 16'($urandom_range(2000));
          c.bytes_available = c.chunk_length;
        end
      end
      send_chunk(c);
    end
  endtask

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    next_tx_tsn = 32'd0;
    for (int i = 0; i < NStreams; i++) next_tx_ssn[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tracking off, reset payload limit
    send_chunk(make_chunk(32'd5, 16'd0, 16'd1, 1'b0, 16'd10));
    send_chunk(make_chunk(32'd6, 16'd0, 16'd0, 1'b0, 16'd0));
    send_chunk(make_chunk(32'd7, 16'd15, 16'hffff, 1'b0, 16'd1200));
    send_chunk(make_chunk(32'd7, 16'd3, 16'd0, 1'b1, 16'd1201));
    send_chunk(make_chunk(32'd7, 16'd16, 16'd0, 1'b1, 16'd4));
    send_chunk(make_chunk(32'd7, 16'hffff, 16'd0, 1'b0, 16'd4));
    begin
      sdr_in_t c;
      c = make_chunk(32'd1, 16'd2, 16'd0, 1'b1, 16'd0);
      c.chunk_length = 16'd15;
      send_chunk(c);
      c.bytes_available = 16'd10;
      send_chunk(c);
      c.chunk_length = 16'd40;
      c.bytes_available = 16'd39;
      send_chunk(c);
      c.chunk_length = 16'hffff;
      c.bytes_available = 16'hffff;
      c.protocol_id = 32'hffff_ffff;
      c.payload_handle = 16'hffff;
      c.chunk_tsn = 32'hffff_ffff;
      send_chunk(c);
    end
    // fill the table on stream 1 to hit the full case
    for (int i = 2; i < 12; i++) send_chunk(make_chunk(32'd0, 16'd1, 16'(i), 1'b0, 16'd8));
    send_chunk(make_chunk(32'd0, 16'd1, 16'd0, 1'b0, 16'd8));
    send_chunk(make_chunk(32'd0, 16'd1, 16'd1, 1'b0, 16'd8));
    send_chunk(make_chunk(32'd0, 16'd1, 16'd0, 1'b0, 16'd8));
    drain();

    // tracking on, tsn wraps, max payload at the top
    write_reg(RegPeerTsn, 32'hffff_fffe);
    write_reg(RegAckOn, 32'd1);
    write_reg(RegMaxPay, 32'd65519);
    next_tx_tsn = 32'hffff_fffe;
    send_chunk(make_chunk(32'hffff_fffe, 16'd4, 16'd0, 1'b0, 16'd65519));
    send_chunk(make_chunk(32'hffff_fffe, 16'd4, 16'd1, 1'b0, 16'd3));
    send_chunk(make_chunk(32'h0000_0005, 16'd4, 16'd2, 1'b0, 16'd3));
    send_chunk(make_chunk(32'hffff_ffff, 16'd4, 16'd1, 1'b0, 16'd3));
    next_tx_tsn = 32'd0;
    drain();
    for (int i = 0; i < NStreams; i++) next_tx_ssn[i] = sb.exp_ssn[i];
    random_phase(110);
    drain();

    send_idle_pct = 88;
    write_reg(RegMaxPay, 32'd0);
    random_phase(40);
    drain();
    write_reg(RegMaxPay, 32'd400);
    random_phase(70);
    drain();

    recv_stall_pct = 88;
    send_idle_pct = 0;
    write_reg(RegAckOn, 32'd0);
    random_phase(110);
    drain();

    send_idle_pct = 10;
    recv_stall_pct = 10;
    write_reg(RegPeerTsn, 32'h1234_5678);
    write_reg(RegAckOn, 32'd1);
    next_tx_tsn = 32'h1234_5678;
    for (int i = 0; i < NStreams; i++) next_tx_ssn[i] = sb.exp_ssn[i];
    random_phase(110);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ sctp_data_receive_reorder.f @@
+incdir+rtl
rtl/sdr_pkg.sv
rtl/sdr_ctrl.sv
rtl/sdr_datapath.sv
rtl/sctp_data_receive_reorder.sv
rtl/sdr_checker.sv
verif/tb_sctp_data_receive_reorder.sv
